### rtl/mtep_pkg.sv
// Shared types, constants and helper functions of the MIDI track event parser.
package mtep_pkg;

    // Longest variable-length quantity, in bytes, for delta times and lengths.
    localparam int unsigned VLQ_MAX_BYTES = 4;
    localparam int unsigned VLQ_ACC_W     = 7 * VLQ_MAX_BYTES;
    localparam int unsigned VLQ_CNT_W     = $clog2(VLQ_MAX_BYTES + 1);
    localparam int unsigned SIZE_W        = 16;
    localparam int unsigned CMP_W         = (VLQ_ACC_W > SIZE_W) ? VLQ_ACC_W : SIZE_W;

    // Byte queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SIZE_W-1:0] MAX_DATA_SIZE_RESET = 16'd4096;

    // Status byte values and masks.
    localparam logic [7:0] STATUS_META      = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_CNT = 8'hF7;
    localparam logic [3:0] SYSTEM_NIBBLE    = 4'hF;
    localparam logic [3:0] NOTE_ON_NIBBLE   = 4'h9;
    localparam logic [2:0] ONE_BYTE_GROUP   = 3'b110;
    localparam logic [6:0] META_END_OF_TRACK = 7'h2F;

    // Error codes of a result.
    localparam logic [2:0] ERR_OK           = 3'd0;
    localparam logic [2:0] ERR_VLQ_LONG     = 3'd1;
    localparam logic [2:0] ERR_NO_STATUS    = 3'd2;
    localparam logic [2:0] ERR_BAD_META     = 3'd3;
    localparam logic [2:0] ERR_META_SIZE    = 3'd4;
    localparam logic [2:0] ERR_SYSEX_SIZE   = 3'd5;
    localparam logic [2:0] ERR_CONT_SIZE    = 3'd6;
    localparam logic [2:0] ERR_UNDEF_STATUS = 3'd7;

    typedef enum logic [2:0] {
        CLS_DATA,
        CLS_CHANNEL,
        CLS_META,
        CLS_SYSEX,
        CLS_UNDEF
    } byte_class_t;

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_METATYPE,
        PH_LENGTH,
        PH_DATA
    } phase_t;

    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  data;
        logic        track_start;
    } q_entry_t;

    typedef struct packed {
        logic [31:0]       tick;
        logic [7:0]        status;
        logic [6:0]        meta_kind;
        logic [SIZE_W-1:0] size;
        logic [7:0]        first;
        logic [7:0]        second;
        logic              note_on;
        logic              end_of_track;
        logic [2:0]        err;
    } res_t;

    function automatic logic is_channel(input logic [7:0] s);
        return s[7] && (s[7:4] != SYSTEM_NIBBLE);
    endfunction

    // Program change and channel pressure carry one data byte, the rest two.
    function automatic logic [SIZE_W-1:0] chan_data_len(input logic [7:0] s);
        return (s[7:5] == ONE_BYTE_GROUP) ? SIZE_W'(1) : SIZE_W'(2);
    endfunction

endpackage

### rtl/mtep_front.sv
// Front part: accepts input beats, classifies each byte and pushes it into the queue.
module mtep_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 track_start,
    input  logic                 q_full,
    output logic                 q_push,
    output mtep_pkg::q_entry_t   q_entry
);

    mtep_pkg::byte_class_t cls;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        if (!data_byte[7])
        begin
            cls = mtep_pkg::CLS_DATA;
        end
        else if (mtep_pkg::is_channel(data_byte))
        begin
            cls = mtep_pkg::CLS_CHANNEL;
        end
        else if (data_byte == mtep_pkg::STATUS_META)
        begin
            cls = mtep_pkg::CLS_META;
        end
        else if (data_byte == mtep_pkg::STATUS_SYSEX || data_byte == mtep_pkg::STATUS_SYSEX_CNT)
        begin
            cls = mtep_pkg::CLS_SYSEX;
        end
        else
        begin
            cls = mtep_pkg::CLS_UNDEF;
        end
    end

    assign q_entry.cls         = cls;
    assign q_entry.data        = data_byte;
    assign q_entry.track_start = track_start;

endmodule

### rtl/mtep_queue.sv
// Short first-in first-out queue of classified bytes between front and back.
module mtep_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mtep_pkg::q_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output mtep_pkg::q_entry_t pop_entry
);

    mtep_pkg::q_entry_t                 mem_reg [mtep_pkg::QUEUE_DEPTH];
    logic [mtep_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [mtep_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [mtep_pkg::QCNT_W-1:0]        count_reg, count_next;

    assign full      = (count_reg == mtep_pkg::QCNT_W'(mtep_pkg::QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mtep_pkg::QPTR_W'(mtep_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + mtep_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mtep_pkg::QPTR_W'(mtep_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + mtep_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + mtep_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - mtep_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/mtep_back.sv
// Back part: parses a queued byte per cycle unless output stalls; registers results.
module mtep_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mtep_pkg::SIZE_W-1:0]   cfg_wr_data,
    input  logic                          q_valid,
    input  mtep_pkg::q_entry_t            q_entry,
    output logic                          q_pop,
    output logic                          res_valid,
    input  logic                          res_ready,
    output mtep_pkg::res_t                res
);

    localparam int unsigned AW = mtep_pkg::VLQ_ACC_W;
    localparam int unsigned CW = mtep_pkg::VLQ_CNT_W;
    localparam int unsigned SW = mtep_pkg::SIZE_W;

    mtep_pkg::phase_t  phase_reg, phase_next, eff_phase;
    logic              halted_reg, halted_next, eff_halted;
    logic [7:0]        running_reg, running_next, eff_running;
    logic [31:0]       tick_reg, tick_next, eff_tick;
    logic [AW-1:0]     acc_reg, acc_next, eff_acc, acc_shift;
    logic [CW-1:0]     cnt_reg, cnt_next, eff_cnt, cnt_inc;
    logic [7:0]        status_reg, status_next;
    logic [6:0]        meta_reg, meta_next;
    logic [SW-1:0]     size_reg, size_next;
    logic [SW-1:0]     rem_reg, rem_next;
    logic [SW-1:0]     pos;
    logic [SW-1:0]     rs_len;
    logic [7:0]        cap0_reg, cap0_next, cap1_reg, cap1_next;
    logic [SW-1:0]     max_size_reg;
    logic              res_valid_reg;
    mtep_pkg::res_t    res_reg, res_d;

    logic [7:0]        b;
    logic              ts;
    logic              vlq_long, size_bad, len_zero, rs_chan, rem_zero, rem_one;
    logic              active, fault, done, fire;
    logic [2:0]        err;

    assign b  = q_entry.data;
    assign ts = q_entry.track_start;

    // A track start clears the parse context before its byte is parsed.
    assign eff_phase   = ts ? mtep_pkg::PH_DELTA : phase_reg;
    assign eff_halted  = ts ? 1'b0 : halted_reg;
    assign eff_running = ts ? 8'd0 : running_reg;
    assign eff_tick    = ts ? 32'd0 : tick_reg;
    assign eff_acc     = ts ? '0 : acc_reg;
    assign eff_cnt     = ts ? '0 : cnt_reg;

    assign acc_shift = AW'({eff_acc, b[6:0]});
    assign cnt_inc   = eff_cnt + CW'(1);
    assign vlq_long  = b[7] && (cnt_inc >= CW'(mtep_pkg::VLQ_MAX_BYTES));
    assign size_bad  = (mtep_pkg::CMP_W'(acc_shift) >= mtep_pkg::CMP_W'(max_size_reg));
    assign len_zero  = (acc_shift == '0);
    assign rs_chan   = mtep_pkg::is_channel(eff_running);
    assign rs_len    = mtep_pkg::chan_data_len(eff_running);
    assign rem_zero  = (rem_reg == '0);
    assign rem_one   = (rem_reg == SW'(1));
    assign pos       = size_reg - rem_reg;

    assign q_pop  = q_valid && (!res_valid_reg || res_ready);
    assign active = q_pop && !eff_halted;
    assign fault  = (err != mtep_pkg::ERR_OK);
    assign fire   = active && (fault || done);

    // Step classification: which fault this byte raises, or whether it ends an event.
    always_comb
    begin
        err  = mtep_pkg::ERR_OK;
        done = 1'b0;
        unique case (eff_phase)
            mtep_pkg::PH_DELTA:
            begin
                if (vlq_long)
                begin
                    err = mtep_pkg::ERR_VLQ_LONG;
                end
            end
            mtep_pkg::PH_LENGTH:
            begin
                if (vlq_long)
                begin
                    err = mtep_pkg::ERR_VLQ_LONG;
                end
                else if (!b[7] && size_bad)
                begin
                    if (status_reg == mtep_pkg::STATUS_META)
                    begin
                        err = mtep_pkg::ERR_META_SIZE;
                    end
                    else if (status_reg == mtep_pkg::STATUS_SYSEX)
                    begin
                        err = mtep_pkg::ERR_SYSEX_SIZE;
                    end
                    else
                    begin
                        err = mtep_pkg::ERR_CONT_SIZE;
                    end
                end
                else
                begin
                    done = !b[7] && len_zero;
                end
            end
            mtep_pkg::PH_STATUS:
            begin
                if (q_entry.cls == mtep_pkg::CLS_DATA)
                begin
                    if (!rs_chan)
                    begin
                        err = mtep_pkg::ERR_NO_STATUS;
                    end
                    else
                    begin
                        done = (rs_len == SW'(1));
                    end
                end
                else if (q_entry.cls == mtep_pkg::CLS_UNDEF)
                begin
                    err = mtep_pkg::ERR_UNDEF_STATUS;
                end
            end
            mtep_pkg::PH_METATYPE:
            begin
                if (b[7])
                begin
                    err = mtep_pkg::ERR_BAD_META;
                end
            end
            mtep_pkg::PH_DATA:
            begin
                done = rem_zero || rem_one;
            end
            default:
            begin
                err  = mtep_pkg::ERR_OK;
                done = 1'b0;
            end
        endcase
    end

    // Next phase and halt flag.
    always_comb
    begin
        phase_next  = phase_reg;
        halted_next = halted_reg;
        if (q_pop)
        begin
            phase_next  = eff_phase;
            halted_next = eff_halted;
            if (!eff_halted)
            begin
                if (fault)
                begin
                    halted_next = 1'b1;
                end
                else if (done)
                begin
                    phase_next = mtep_pkg::PH_DELTA;
                end
                else
                begin
                    unique case (eff_phase)
                        mtep_pkg::PH_DELTA:
                        begin
                            phase_next = b[7] ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
                        end
                        mtep_pkg::PH_LENGTH:
                        begin
                            phase_next = b[7] ? mtep_pkg::PH_LENGTH : mtep_pkg::PH_DATA;
                        end
                        mtep_pkg::PH_STATUS:
                        begin
                            if (q_entry.cls == mtep_pkg::CLS_META)
                            begin
                                phase_next = mtep_pkg::PH_METATYPE;
                            end
                            else if (q_entry.cls == mtep_pkg::CLS_SYSEX)
                            begin
                                phase_next = mtep_pkg::PH_LENGTH;
                            end
                            else
                            begin
                                phase_next = mtep_pkg::PH_DATA;
                            end
                        end
                        mtep_pkg::PH_METATYPE:
                        begin
                            phase_next = mtep_pkg::PH_LENGTH;
                        end
                        mtep_pkg::PH_DATA:
                        begin
                            phase_next = mtep_pkg::PH_DATA;
                        end
                        default:
                        begin
                            phase_next = mtep_pkg::PH_DELTA;
                        end
                    endcase
                end
            end
        end
    end

    // Parse context updates.
    always_comb
    begin
        tick_next    = tick_reg;
        running_next = running_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        meta_next    = meta_reg;
        size_next    = size_reg;
        rem_next     = rem_reg;
        cap0_next    = cap0_reg;
        cap1_next    = cap1_reg;
        if (q_pop)
        begin
            tick_next    = eff_tick;
            running_next = eff_running;
            acc_next     = eff_acc;
            cnt_next     = eff_cnt;
        end
        if (active && !fault)
        begin
            unique case (eff_phase)
                mtep_pkg::PH_DELTA, mtep_pkg::PH_LENGTH:
                begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    if (!b[7])
                    begin
                        if (eff_phase == mtep_pkg::PH_DELTA)
                        begin
                            tick_next = eff_tick + 32'(acc_shift);
                        end
                        else
                        begin
                            size_next = SW'(acc_shift);
                            rem_next  = SW'(acc_shift);
                        end
                    end
                end
                mtep_pkg::PH_STATUS:
                begin
                    meta_next = '0;
                    cap0_next = '0;
                    cap1_next = '0;
                    unique case (q_entry.cls)
                        mtep_pkg::CLS_DATA:
                        begin
                            // Running status: this byte is already the first data byte.
                            status_next = eff_running;
                            size_next   = rs_len;
                            rem_next    = rs_len - SW'(1);
                            cap0_next   = b;
                        end
                        mtep_pkg::CLS_CHANNEL:
                        begin
                            status_next = b;
                            size_next   = mtep_pkg::chan_data_len(b);
                            rem_next    = mtep_pkg::chan_data_len(b);
                        end
                        mtep_pkg::CLS_META, mtep_pkg::CLS_SYSEX:
                        begin
                            status_next = b;
                            size_next   = '0;
                            rem_next    = '0;
                            acc_next    = '0;
                            cnt_next    = '0;
                        end
                        default:
                        begin
                            status_next = status_reg;
                        end
                    endcase
                end
                mtep_pkg::PH_METATYPE:
                begin
                    meta_next = b[6:0];
                    acc_next  = '0;
                    cnt_next  = '0;
                end
                mtep_pkg::PH_DATA:
                begin
                    if (!rem_zero)
                    begin
                        if (pos == SW'(0))
                        begin
                            cap0_next = b;
                        end
                        if (pos == SW'(1))
                        begin
                            cap1_next = b;
                        end
                        rem_next = rem_reg - SW'(1);
                    end
                end
                default:
                begin
                    acc_next = '0;
                    cnt_next = '0;
                end
            endcase
            if (done)
            begin
                // Channel messages set running status, sysex clears it, meta keeps it.
                if (mtep_pkg::is_channel(status_next))
                begin
                    running_next = status_next;
                end
                else if (status_next != mtep_pkg::STATUS_META)
                begin
                    running_next = '0;
                end
                acc_next = '0;
                cnt_next = '0;
            end
        end
    end

    // Result of the step, taken from the updated event context.
    always_comb
    begin
        res_d      = '0;
        res_d.tick = eff_tick;
        if (fault)
        begin
            res_d.err = err;
        end
        else
        begin
            res_d.status       = status_next;
            res_d.meta_kind    = (status_next == mtep_pkg::STATUS_META) ? meta_next : '0;
            res_d.size         = size_next;
            res_d.first        = cap0_next;
            res_d.second       = cap1_next;
            res_d.note_on      = (status_next[7:4] == mtep_pkg::NOTE_ON_NIBBLE)
                                 && (cap1_next != '0);
            res_d.end_of_track = (status_next == mtep_pkg::STATUS_META)
                                 && (meta_next == mtep_pkg::META_END_OF_TRACK);
            res_d.err          = mtep_pkg::ERR_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mtep_pkg::PH_DELTA;
            halted_reg    <= 1'b0;
            running_reg   <= '0;
            tick_reg      <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            status_reg    <= '0;
            meta_reg      <= '0;
            size_reg      <= '0;
            rem_reg       <= '0;
            cap0_reg      <= '0;
            cap1_reg      <= '0;
            max_size_reg  <= mtep_pkg::MAX_DATA_SIZE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            halted_reg  <= halted_next;
            running_reg <= running_next;
            tick_reg    <= tick_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            status_reg  <= status_next;
            meta_reg    <= meta_next;
            size_reg    <= size_next;
            rem_reg     <= rem_next;
            cap0_reg    <= cap0_next;
            cap1_reg    <= cap1_next;
            if (cfg_wr_en)
            begin
                max_size_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_d;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### rtl/midi_track_event_parser_core.sv
// Top level of the MIDI track event parser: front, byte queue and back.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-----------------------------------------------
//  input   | in_valid / in_ready    | data_byte, track_start
//  output  | out_valid / out_ready  | event_tick, event_status, meta_kind,
//          |                        | payload_size, first_data, second_data,
//          |                        | sounding_note_on, end_of_track, error_code
//  config  | cfg_wr_en              | cfg_wr_data (max_data_size)
//
// Rate: one byte beat per cycle, sustained, as long as results are taken.
// Path: an accepted byte is written into the queue, the back pops it from the head and
// registers the result of the event that the byte ends in the output register.
// The front and back are parted by a four-entry queue; the back also owns the
// output register, so a stalled output stops only the back while the queue fills.
// Reset clears the parse context, empties the queue and sets max_data_size to 4096.
module midi_track_event_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        track_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] event_tick,
    output logic [7:0]  event_status,
    output logic [6:0]  meta_kind,
    output logic [15:0] payload_size,
    output logic [7:0]  first_data,
    output logic [7:0]  second_data,
    output logic        sounding_note_on,
    output logic        end_of_track,
    output logic [2:0]  error_code
);

    // Classified byte beats travel from the front to the back through this queue.
    logic               q_push, q_full, q_pop, q_valid;
    mtep_pkg::q_entry_t push_entry, pop_entry;
    mtep_pkg::res_t     res;

    mtep_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .track_start (track_start),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    mtep_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .pop_entry  (pop_entry)
    );

    // The back runs the delta-time, status, meta-type, length and data phases of each event.
    // An error result halts parsing until a byte beat with track_start set.
    mtep_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .res_valid   (out_valid),
        .res_ready   (out_ready),
        .res         (res)
    );

    // Split the registered result into its output fields.
    assign event_tick       = res.tick;
    assign event_status     = res.status;
    assign meta_kind        = res.meta_kind;
    assign payload_size     = res.size;
    assign first_data       = res.first;
    assign second_data      = res.second;
    assign sounding_note_on = res.note_on;
    assign end_of_track     = res.end_of_track;
    assign error_code       = res.err;

endmodule

### rtl/mtep_checker.sv
// Port-level checker of the MIDI track event parser and its bind statement.
module mtep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wr_en,
    input logic [15:0] cfg_wr_data,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  data_byte,
    input logic        track_start,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] event_tick,
    input logic [7:0]  event_status,
    input logic [6:0]  meta_kind,
    input logic [15:0] payload_size,
    input logic [7:0]  first_data,
    input logic [7:0]  second_data,
    input logic        sounding_note_on,
    input logic        end_of_track,
    input logic [2:0]  error_code
);

    // A stalled result beat stays valid and keeps its tick and error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_tick) && $stable(error_code))
        else $error("result beat changed while stalled");

    // An error result carries only the tick and the code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != mtep_pkg::ERR_OK) |->
            (event_status == 8'd0) && (meta_kind == 7'd0) && (payload_size == 16'd0) &&
            (first_data == 8'd0) && (second_data == 8'd0) &&
            !sounding_note_on && !end_of_track)
        else $error("error result carries event fields");

    // End of track is only ever flagged on the matching meta event.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_track |->
            (event_status == mtep_pkg::STATUS_META) &&
            (meta_kind == mtep_pkg::META_END_OF_TRACK))
        else $error("end of track flagged on a different event");

    // A sounding note-on needs a note-on status and a nonzero velocity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sounding_note_on |->
            (event_status[7:4] == mtep_pkg::NOTE_ON_NIBBLE) && (second_data != 8'd0))
        else $error("sounding note-on flag without note-on data");

endmodule

bind midi_track_event_parser_core mtep_checker u_mtep_checker (.*);

### verif/midi_track_event_parser_core_tb.sv
// Self-checking testbench for the MIDI track event parser with a byte-level parse predictor.

// Scoreboard: it follows the parse of every accepted byte beat, queues the
// event it predicts and checks every result beat against the oldest entry.
class midi_track_scoreboard;
    logic [15:0]       size_limit;
    mtep_pkg::phase_t  phase;
    logic [7:0]        run_status;
    logic [31:0]       tick;
    logic [63:0]       qty;
    int unsigned       qty_bytes;
    logic [7:0]        cur_status;
    logic [6:0]        cur_meta;
    int unsigned       ev_size;
    int unsigned       remaining;
    logic [7:0]        captured [2];
    bit                halted;
    mtep_pkg::res_t    due_events [$];
    int                errors;

    function new();
        size_limit  = mtep_pkg::MAX_DATA_SIZE_RESET;
        phase       = mtep_pkg::PH_DELTA;
        run_status  = 8'h00;
        tick        = '0;
        qty         = '0;
        qty_bytes   = 0;
        cur_status  = 8'h00;
        cur_meta    = 7'h00;
        ev_size     = 0;
        remaining   = 0;
        captured[0] = 8'h00;
        captured[1] = 8'h00;
        halted      = 1'b0;
        errors      = 0;
    endfunction

    function bit is_voice_status(logic [7:0] s);
        return (s >= 8'h80) && (s < 8'hF0);
    endfunction

    // A fault result carries only the tick and the code, and halts the parse.
    function void push_fault(logic [2:0] code);
        mtep_pkg::res_t r;
        r      = '0;
        r.tick = tick;
        r.err  = code;
        halted = 1'b1;
        due_events.push_back(r);
    endfunction

    function void push_event();
        mtep_pkg::res_t r;
        bit             meta;
        meta           = (cur_status == mtep_pkg::STATUS_META);
        r.tick         = tick;
        r.status       = cur_status;
        r.meta_kind    = meta ? cur_meta : 7'h00;
        r.size         = ev_size[15:0];
        r.first        = captured[0];
        r.second       = captured[1];
        r.note_on      = (cur_status[7:4] == mtep_pkg::NOTE_ON_NIBBLE)
                         && (captured[1] != 8'h00);
        r.end_of_track = meta && (cur_meta == mtep_pkg::META_END_OF_TRACK);
        r.err          = mtep_pkg::ERR_OK;
        due_events.push_back(r);
        // Channel messages set running status, sysex clears it, meta leaves it.
        if (is_voice_status(cur_status))
            run_status = cur_status;
        else if (!meta)
            run_status = 8'h00;
        phase     = mtep_pkg::PH_DELTA;
        qty       = '0;
        qty_bytes = 0;
    endfunction

    function void start_event(logic [7:0] s);
        cur_status  = s;
        cur_meta    = 7'h00;
        captured[0] = 8'h00;
        captured[1] = 8'h00;
        ev_size     = (s[7:5] == mtep_pkg::ONE_BYTE_GROUP) ? 1 : 2;
        remaining   = ev_size;
    endfunction

    function void take_data(logic [7:0] b);
        int unsigned pos;
        pos = ev_size - remaining;
        if (pos < 2)
            captured[pos[0]] = b;
        remaining--;
    endfunction

    // Notes one accepted byte beat. Returns 0 when the parser ignores it.
    function bit parse_byte(logic [7:0] b, bit start);
        if (start)
        begin
            tick       = '0;
            run_status = 8'h00;
            phase      = mtep_pkg::PH_DELTA;
            qty        = '0;
            qty_bytes  = 0;
            halted     = 1'b0;
        end
        if (halted)
            return 1'b0;
        case (phase)
            mtep_pkg::PH_DELTA, mtep_pkg::PH_LENGTH:
            begin
                qty = (qty << 7) | 64'(b[6:0]);
                qty_bytes++;
                if (b[7])
                begin
                    if (qty_bytes >= mtep_pkg::VLQ_MAX_BYTES)
                        push_fault(mtep_pkg::ERR_VLQ_LONG);
                    return 1'b1;
                end
                if (phase == mtep_pkg::PH_DELTA)
                begin
                    tick  = tick + qty[31:0];
                    phase = mtep_pkg::PH_STATUS;
                    return 1'b1;
                end
                if (qty >= 64'(size_limit))
                begin
                    if (cur_status == mtep_pkg::STATUS_META)
                        push_fault(mtep_pkg::ERR_META_SIZE);
                    else if (cur_status == mtep_pkg::STATUS_SYSEX)
                        push_fault(mtep_pkg::ERR_SYSEX_SIZE);
                    else
                        push_fault(mtep_pkg::ERR_CONT_SIZE);
                    return 1'b1;
                end
                ev_size   = qty[31:0];
                remaining = ev_size;
                if (ev_size == 0)
                    push_event();
                else
                    phase = mtep_pkg::PH_DATA;
            end
            mtep_pkg::PH_STATUS:
            begin
                if (!b[7])
                begin
                    if (!is_voice_status(run_status))
                    begin
                        push_fault(mtep_pkg::ERR_NO_STATUS);
                        return 1'b1;
                    end
                    start_event(run_status);
                    take_data(b);
                    if (remaining == 0)
                        push_event();
                    else
                        phase = mtep_pkg::PH_DATA;
                end
                else if (is_voice_status(b))
                begin
                    start_event(b);
                    phase = mtep_pkg::PH_DATA;
                end
                else if (b == mtep_pkg::STATUS_META || b == mtep_pkg::STATUS_SYSEX
                         || b == mtep_pkg::STATUS_SYSEX_CNT)
                begin
                    start_event(b);
                    ev_size   = 0;
                    remaining = 0;
                    qty       = '0;
                    qty_bytes = 0;
                    phase     = (b == mtep_pkg::STATUS_META) ? mtep_pkg::PH_METATYPE
                                                             : mtep_pkg::PH_LENGTH;
                end
                else
                begin
                    push_fault(mtep_pkg::ERR_UNDEF_STATUS);
                end
            end
            mtep_pkg::PH_METATYPE:
            begin
                if (b[7])
                begin
                    push_fault(mtep_pkg::ERR_BAD_META);
                    return 1'b1;
                end
                cur_meta  = b[6:0];
                qty       = '0;
                qty_bytes = 0;
                phase     = mtep_pkg::PH_LENGTH;
            end
            mtep_pkg::PH_DATA:
            begin
                if (remaining == 0)
                begin
                    push_event();
                    return 1'b1;
                end
                take_data(b);
                if (remaining == 0)
                    push_event();
            end
            default:
            begin
                phase     = mtep_pkg::PH_DELTA;
                qty       = '0;
                qty_bytes = 0;
            end
        endcase
        return 1'b1;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
            errors++;
        end
    endfunction

    function void check_result(mtep_pkg::res_t got);
        mtep_pkg::res_t want;
        if (due_events.size() == 0)
        begin
            $error("result beat with no event pending: tick 0x%0h status 0x%0h",
                   got.tick, got.status);
            errors++;
            return;
        end
        want = due_events.pop_front();
        compare_field("event_tick", want.tick, got.tick);
        compare_field("event_status", 32'(want.status), 32'(got.status));
        compare_field("meta_kind", 32'(want.meta_kind), 32'(got.meta_kind));
        compare_field("payload_size", 32'(want.size), 32'(got.size));
        compare_field("first_data", 32'(want.first), 32'(got.first));
        compare_field("second_data", 32'(want.second), 32'(got.second));
        compare_field("sounding_note_on", 32'(want.note_on), 32'(got.note_on));
        compare_field("end_of_track", 32'(want.end_of_track), 32'(got.end_of_track));
        compare_field("error_code", 32'(want.err), 32'(got.err));
    endfunction
endclass

module midi_track_event_parser_core_tb;

    // The slowest correct run stays far below this; it only catches a hang.
    localparam int unsigned CYCLE_LIMIT    = 600_000;
    localparam int unsigned PHASE_COUNT    = 7;
    localparam int unsigned PHASE_QUOTA    = 272;
    localparam int unsigned HOLD_CYCLES    = 60;
    // Settle time after the last predicted event, with ample margin for bytes that
    // end no event and are still on their way through the queue.
    localparam int unsigned SETTLE_CYCLES  = 12;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        track_start;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] event_tick;
    logic [7:0]  event_status;
    logic [6:0]  meta_kind;
    logic [15:0] payload_size;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic        sounding_note_on;
    logic        end_of_track;
    logic [2:0]  error_code;

    midi_track_scoreboard track_sb = new();

    logic [7:0]  ev_bytes [$];
    int unsigned items_parsed = 0;
    int unsigned cycle_count  = 0;
    bit          tx_burst     = 1'b0;
    bit          rx_burst     = 1'b0;
    bit          hold_req     = 1'b0;
    bit          wide_ticks   = 1'b0;

    // Directed opening: sounding note-on, running status with zero velocity,
    // the widest delta, a one-byte channel message, end of track with an empty
    // body, an empty sysex that clears running status, a data byte with no
    // status, and a delta time that runs one byte too long.
    logic [8:0] directed_beats [26] = '{
        9'h100, 9'h090, 9'h03C, 9'h064,
        9'h07F, 9'h03C, 9'h000,
        9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h0C5, 9'h07F,
        9'h000, 9'h0FF, 9'h02F, 9'h000,
        9'h000, 9'h0F0, 9'h000,
        9'h000, 9'h040,
        9'h181, 9'h080, 9'h080, 9'h080
    };

    midi_track_event_parser_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .track_start      (track_start),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_tick       (event_tick),
        .event_status     (event_status),
        .meta_kind        (meta_kind),
        .payload_size     (payload_size),
        .first_data       (first_data),
        .second_data      (second_data),
        .sounding_note_on (sounding_note_on),
        .end_of_track     (end_of_track),
        .error_code       (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("midi_track_event_parser_core_tb: done, errors");
            $finish;
        end
    end

    // Every result beat is checked at the edge that takes it.
    always @(posedge clk)
    begin : result_monitor
        mtep_pkg::res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.tick         = event_tick;
            got.status       = event_status;
            got.meta_kind    = meta_kind;
            got.size         = payload_size;
            got.first        = first_data;
            got.second       = second_data;
            got.note_on      = sounding_note_on;
            got.end_of_track = end_of_track;
            got.err          = error_code;
            track_sb.check_result(got);
        end
    end

    // Result side: random stalls per beat, stall-free stretches, and on request
    // one long hold-off so that the queue fills and the input side backs up.
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                rx_burst = !rx_burst;
            if (hold_req)
            begin
                @(negedge clk) out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = rx_burst ? 0 : $urandom_range(0, 8);
                if (stall > 0)
                begin
                    @(negedge clk) out_ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
            @(negedge clk) out_ready <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (out_valid || hold_req)
                    break;
            end
        end
    end

    // Offers one byte beat, holds it until taken, then feeds the predictor.
    task automatic send_byte(logic [7:0] b, bit start);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        data_byte   <= b;
        track_start <= start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (track_sb.parse_byte(b, start))
            items_parsed++;
    endtask

    // Stops offering bytes until every predicted event has come out.
    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        while (track_sb.due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void push_vlq(logic [27:0] value, bit pad);
        int n;
        int i;
        n = 1;
        while (n < mtep_pkg::VLQ_MAX_BYTES && (value >> (7 * n)) != '0)
            n++;
        // Leading 0x80 bytes are legal padding and lengthen the quantity.
        if (pad)
            n = $urandom_range(n, mtep_pkg::VLQ_MAX_BYTES);
        for (i = n - 1; i >= 0; i--)
            ev_bytes.push_back({i != 0, 7'(value >> (7 * i))});
    endfunction

    // Body length for meta and sysex: mostly short, sometimes just under, at or past
    // the size limit, sometimes a wide quantity the size check must reject.
    function automatic int unsigned pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 75)
            return $urandom_range(1, 6);
        if (r < 85)
            return $urandom_range(7, 40);
        if (r < 90 && track_sb.size_limit != 16'd0 && track_sb.size_limit <= 16'd65)
            return 32'(track_sb.size_limit) - 1;
        if (r < 95)
            return 32'(track_sb.size_limit) + $urandom_range(0, 3);
        return $urandom_range(32'h0000FFFF, 32'h0FFFFFFF);
    endfunction

    // Builds one event with random content and sends it. Most events are well
    // formed; the rest are noise or broken on purpose.
    task automatic play_random_event();
        int          r;
        int          n;
        int          k;
        int unsigned len;
        bit          restart;
        logic [7:0]  rs;
        logic [7:0]  st;
        logic [7:0]  d;
        logic [27:0] delta;
        ev_bytes.delete();
        restart = track_sb.halted ? ($urandom_range(0, 9) != 0)
                                  : ($urandom_range(0, 49) == 0);
        if (restart)
            wide_ticks = ($urandom_range(0, 5) == 0);
        rs = restart ? 8'h00 : track_sb.run_status;

        // Some tracks use mostly huge deltas so that the tick count wraps.
        r = $urandom_range(0, 99);
        if (wide_ticks && r < 60)
            delta = 28'($urandom_range(32'h08000000, 32'h0FFFFFFF));
        else if (r < 35)
            delta = '0;
        else if (r < 75)
            delta = 28'($urandom_range(1, 127));
        else if (r < 88)
            delta = 28'($urandom_range(128, 16383));
        else if (r < 95)
            delta = 28'($urandom_range(16384, 32'h001FFFFF));
        else
            delta = 28'($urandom_range(0, 32'h0FFFFFFF));
        push_vlq(delta, $urandom_range(0, 9) == 0);

        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            if (track_sb.is_voice_status(rs) && $urandom_range(0, 1) == 1)
            begin
                st = rs;
            end
            else
            begin
                st = 8'($urandom_range(8'h80, 8'hEF));
                ev_bytes.push_back(st);
            end
            n = (st[7:5] == mtep_pkg::ONE_BYTE_GROUP) ? 1 : 2;
            for (k = 0; k < n; k++)
            begin
                d = 8'($urandom_range(0, 127));
                if (k == 1 && st[7:4] == mtep_pkg::NOTE_ON_NIBBLE && $urandom_range(0, 4) == 0)
                    d = 8'h00;
                ev_bytes.push_back(d);
            end
        end
        else if (r < 80)
        begin
            if (r < 70)
            begin
                ev_bytes.push_back(mtep_pkg::STATUS_META);
                ev_bytes.push_back(($urandom_range(0, 4) == 0) ?
                                   8'(mtep_pkg::META_END_OF_TRACK) :
                                   8'($urandom_range(0, 127)));
            end
            else
            begin
                ev_bytes.push_back(($urandom_range(0, 1) != 0) ? mtep_pkg::STATUS_SYSEX
                                                               : mtep_pkg::STATUS_SYSEX_CNT);
            end
            len = pick_length();
            push_vlq(28'(len), $urandom_range(0, 9) == 0);
            if (len < 32'(track_sb.size_limit))
                for (k = 0; k < int'(len); k++)
                    ev_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 86)
        begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
                ev_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    // System common and real-time codes have no place here.
                    st = 8'($urandom_range(8'hF1, 8'hFE));
                    if (st == mtep_pkg::STATUS_SYSEX_CNT)
                        st = 8'hF4;
                    ev_bytes.push_back(st);
                end
                1:
                begin
                    ev_bytes.push_back(mtep_pkg::STATUS_META);
                    ev_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
                end
                2:
                begin
                    ev_bytes.delete();
                    for (k = 0; k < mtep_pkg::VLQ_MAX_BYTES; k++)
                        ev_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                end
                3:
                begin
                    // An empty sysex clears running status, so the data byte
                    // that follows the next delta has no status to use.
                    ev_bytes.push_back(mtep_pkg::STATUS_SYSEX);
                    ev_bytes.push_back(8'h00);
                    ev_bytes.push_back(8'h00);
                    ev_bytes.push_back(8'($urandom_range(0, 127)));
                end
                default:
                begin
                    ev_bytes.push_back(mtep_pkg::STATUS_META);
                    ev_bytes.push_back(8'($urandom_range(0, 127)));
                    for (k = 0; k < mtep_pkg::VLQ_MAX_BYTES; k++)
                        ev_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                end
            endcase
        end

        // Once the parse halts, the rest of the event would only be ignored.
        for (k = 0; k < ev_bytes.size(); k++)
        begin
            if (k > 0 && track_sb.halted)
                break;
            send_byte(ev_bytes[k], restart && k == 0);
        end
    endtask

    initial
    begin : stimulus
        logic [15:0] lim;
        int unsigned stop_at;
        int unsigned hold_at;
        int unsigned pause_at;
        bit          held;
        bit          paused;
        int          p;
        int          i;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 16'h0000;
        in_valid    = 1'b0;
        data_byte   = 8'h00;
        track_start = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (i = 0; i < 26; i++)
            send_byte(directed_beats[i][7:0], directed_beats[i][8]);

        // Size limit settings: reset value, the maximum, zero (everything with
        // a body length rejected), one, a small value, a random one, then back.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            if (p > 0)
            begin
                drain();
                case (p)
                    1: lim = 16'hFFFF;
                    2: lim = 16'h0000;
                    3: lim = 16'h0001;
                    4: lim = 16'h0008;
                    5: lim = 16'($urandom_range(2, 300));
                    default: lim = mtep_pkg::MAX_DATA_SIZE_RESET;
                endcase
                @(negedge clk);
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= lim;
                @(negedge clk) cfg_wr_en <= 1'b0;
                track_sb.size_limit = lim;
            end
            stop_at  = items_parsed + PHASE_QUOTA;
            hold_at  = items_parsed + PHASE_QUOTA / 3;
            pause_at = items_parsed + 2 * PHASE_QUOTA / 3;
            held     = 1'b0;
            paused   = 1'b0;
            while (items_parsed < stop_at)
            begin
                if (!held && items_parsed >= hold_at)
                begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                if (!paused && items_parsed >= pause_at)
                begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 19) == 0)
                    tx_burst = !tx_burst;
                play_random_event();
            end
        end

        drain();
        if (track_sb.errors == 0 && track_sb.due_events.size() == 0)
            $display("midi_track_event_parser_core_tb: done, clean");
        else
            $display("midi_track_event_parser_core_tb: done, errors");
        $finish;
    end

endmodule

### midi_track_event_parser_core.f
rtl/mtep_pkg.sv
rtl/mtep_front.sv
rtl/mtep_queue.sv
rtl/mtep_back.sv
rtl/midi_track_event_parser_core.sv
rtl/mtep_checker.sv
verif/midi_track_event_parser_core_tb.sv
